@@ design/x86d_pkg.sv @@
// Shared opcodes, codes, payload structs and operand helpers for the x86 subset decoder.
`timescale 1ns / 1ps

package x86d_pkg;

  localparam logic [7:0] OP_MOV_STORE     = 8'h89;
  localparam logic [7:0] OP_ALU_IMM8      = 8'h83;
  localparam logic [7:0] OP_JNE           = 8'h75;
  localparam logic [7:0] OP_CALL          = 8'hE8;
  localparam logic [7:0] OP_MOV_IMM       = 8'hB8;
  localparam logic [7:0] OP_MOV_IMM_LAST  = 8'hBF;
  localparam logic [7:0] OP_MOVL          = 8'hC7;
  localparam logic [7:0] OP_GRP5          = 8'hFF;
  localparam logic [7:0] OP_PUSH_IMM32    = 8'h68;
  localparam logic [7:0] OP_PUSH_IMM8     = 8'h6A;
  localparam logic [7:0] OP_RET           = 8'hC3;
  localparam logic [7:0] OP_JMP           = 8'hEB;
  localparam logic [7:0] OP_PUSH_REG      = 8'h50;
  localparam logic [7:0] OP_PUSH_REG_LAST = 8'h57;

  localparam logic [1:0] MOD_IND   = 2'd0;
  localparam logic [1:0] MOD_DISP8 = 2'd1;
  localparam logic [1:0] MOD_DISP32 = 2'd2;
  localparam logic [1:0] MOD_REG   = 2'd3;

  localparam logic [2:0] RM_DISP32_ONLY = 3'd5;

  localparam logic [2:0] EXT_ADD  = 3'd0;
  localparam logic [2:0] EXT_SUB  = 3'd5;
  localparam logic [2:0] EXT_CMP  = 3'd7;
  localparam logic [2:0] EXT_MOVL = 3'd0;
  localparam logic [2:0] EXT_PUSH = 3'd6;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_UNSUP   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    KIND_NONE       = 4'd0,
    KIND_MOV_STORE  = 4'd1,
    KIND_ADD        = 4'd2,
    KIND_SUB        = 4'd3,
    KIND_CMP        = 4'd4,
    KIND_JNE        = 4'd5,
    KIND_CALL       = 4'd6,
    KIND_MOV_IMM    = 4'd7,
    KIND_JMP        = 4'd8,
    KIND_MOVL       = 4'd9,
    KIND_PUSH_RM    = 4'd10,
    KIND_PUSH_REG   = 4'd11,
    KIND_PUSH_IMM32 = 4'd12,
    KIND_PUSH_IMM8  = 4'd13,
    KIND_RET        = 4'd14
  } kind_t;

  typedef enum logic [2:0] {
    AM_REG    = 3'd0,
    AM_IND    = 3'd1,
    AM_DISP8  = 3'd2,
    AM_DISP32 = 3'd3,
    AM_ABS    = 3'd4,
    AM_NONE   = 3'd5
  } amode_t;

  typedef struct packed {
    logic [9:0][7:0] bytes;
    logic [31:0]     addr;
  } insn_t;

  typedef struct packed {
    status_t     status;
    kind_t       kind;
    logic [3:0]  length;
    logic [2:0]  reg_field;
    logic [2:0]  rm_field;
    amode_t      addr_mode;
    logic [31:0] displacement;
    logic [31:0] immediate;
    logic [31:0] branch_target;
  } dec_t;

  typedef struct packed {
    amode_t      mode;
    logic [31:0] disp;
    logic [2:0]  n;
  } rm_t;

  function automatic logic [31:0] sext8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic rm_t decode_rm(input logic [9:0][7:0] b);
    rm_t r;
    r.mode = AM_REG;
    r.disp = '0;
    r.n    = 3'd0;
    case (b[1][7:6])
      MOD_IND: begin
        if (b[1][2:0] == RM_DISP32_ONLY) begin
          r.mode = AM_ABS;
          r.disp = b[5:2];
          r.n    = 3'd4;
        end else begin
          r.mode = AM_IND;
        end
      end
      MOD_DISP8: begin
        r.mode = AM_DISP8;
        r.disp = sext8(b[2]);
        r.n    = 3'd1;
      end
      MOD_DISP32: begin
        r.mode = AM_DISP32;
        r.disp = b[5:2];
        r.n    = 3'd4;
      end
      default: begin
        r.mode = AM_REG;
      end
    endcase
    return r;
  endfunction

endpackage

@@ design/x86_subset_instruction_decoder.sv @@
// Top level of the x86 subset instruction decoder: input register, decode, result register.
//
//   channel  handshake           payload
//   in       start / busy        in_insn_byte_0..9, in_insn_address
//   out      out_valid (strobe)  out_status .. out_branch_target
//
// One transaction per cycle; busy stays low. A result passes through the input
// register, one pass of decode logic and the result register, in that order.
// Synchronous active-low reset clears both valid flags.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module x86_subset_instruction_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         in_insn_byte_0,
  input  logic [7:0]         in_insn_byte_1,
  input  logic [7:0]         in_insn_byte_2,
  input  logic [7:0]         in_insn_byte_3,
  input  logic [7:0]         in_insn_byte_4,
  input  logic [7:0]         in_insn_byte_5,
  input  logic [7:0]         in_insn_byte_6,
  input  logic [7:0]         in_insn_byte_7,
  input  logic [7:0]         in_insn_byte_8,
  input  logic [7:0]         in_insn_byte_9,
  input  logic [31:0]        in_insn_address,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [3:0]         out_kind,
  output logic [3:0]         out_length,
  output logic [2:0]         out_reg_field,
  output logic [2:0]         out_rm_field,
  output logic [2:0]         out_addr_mode,
  output logic signed [31:0] out_displacement,
  output logic [31:0]        out_immediate,
  output logic [31:0]        out_branch_target
);

  logic              in_valid_r, in_valid_nxt;
  x86d_pkg::insn_t   in_r, in_nxt;
  logic              out_valid_r;
  x86d_pkg::dec_t    out_r, dec;

  assign busy         = 1'b0;
  assign in_valid_nxt = start & ~busy;
  assign in_nxt.bytes = {in_insn_byte_9, in_insn_byte_8, in_insn_byte_7, in_insn_byte_6,
                         in_insn_byte_5, in_insn_byte_4, in_insn_byte_3, in_insn_byte_2,
                         in_insn_byte_1, in_insn_byte_0};
  assign in_nxt.addr  = in_insn_address;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= in_valid_r;
    end
  end

  // hold payload when no transaction
  always_ff @(posedge clk) begin
    if (in_valid_nxt) begin
      in_r <= in_nxt;
    end
    if (in_valid_r) begin
      out_r <= dec;
    end
  end

  x86d_decode u_decode (
    .insn (in_r),
    .res  (dec)
  );

  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_kind          = out_r.kind;
  assign out_length        = out_r.length;
  assign out_reg_field     = out_r.reg_field;
  assign out_rm_field      = out_r.rm_field;
  assign out_addr_mode     = out_r.addr_mode;
  assign out_displacement  = out_r.displacement;
  assign out_immediate     = out_r.immediate;
  assign out_branch_target = out_r.branch_target;

endmodule

@@ design/x86d_decode.sv @@
// Combinational decode of one instruction window into kind, length and operand fields.
`timescale 1ns / 1ps

module x86d_decode (
  input  x86d_pkg::insn_t insn,
  output x86d_pkg::dec_t  res
);

  logic [9:0][7:0] b;
  logic [7:0]      op;
  logic [2:0]      mreg;
  logic [1:0]      mmod;
  x86d_pkg::rm_t   rm;
  logic [31:0]     offset;
  logic            is_branch;

  assign b    = insn.bytes;
  assign op   = b[0];
  assign mreg = b[1][5:3];
  assign mmod = b[1][7:6];
  assign rm   = x86d_pkg::decode_rm(b);

  always_comb begin
    res           = '0;
    res.status    = x86d_pkg::ST_OK;
    res.kind      = x86d_pkg::KIND_NONE;
    res.addr_mode = x86d_pkg::AM_NONE;
    offset        = '0;
    is_branch     = 1'b0;
    case (op) inside
      x86d_pkg::OP_RET: begin
        res.kind   = x86d_pkg::KIND_RET;
        res.length = 4'd1;
      end
      [x86d_pkg::OP_PUSH_REG:x86d_pkg::OP_PUSH_REG_LAST]: begin
        res.kind      = x86d_pkg::KIND_PUSH_REG;
        res.length    = 4'd1;
        res.reg_field = op[2:0];
      end
      x86d_pkg::OP_MOV_STORE: begin
        res.kind         = x86d_pkg::KIND_MOV_STORE;
        res.reg_field    = mreg;
        res.rm_field     = b[1][2:0];
        res.addr_mode    = rm.mode;
        res.displacement = rm.disp;
        res.length       = 4'd2 + {1'b0, rm.n};
      end
      x86d_pkg::OP_ALU_IMM8: begin
        if ((mreg == x86d_pkg::EXT_ADD || mreg == x86d_pkg::EXT_SUB ||
             mreg == x86d_pkg::EXT_CMP) &&
            (mmod == x86d_pkg::MOD_REG || mmod == x86d_pkg::MOD_DISP8)) begin
          case (mreg)
            x86d_pkg::EXT_ADD: res.kind = x86d_pkg::KIND_ADD;
            x86d_pkg::EXT_SUB: res.kind = x86d_pkg::KIND_SUB;
            default:           res.kind = x86d_pkg::KIND_CMP;
          endcase
          res.reg_field = mreg;
          res.rm_field  = b[1][2:0];
          if (mmod == x86d_pkg::MOD_REG) begin
            res.addr_mode = x86d_pkg::AM_REG;
            res.immediate = {24'd0, b[2]};
            res.length    = 4'd3;
          end else begin
            res.addr_mode    = x86d_pkg::AM_DISP8;
            res.displacement = x86d_pkg::sext8(b[2]);
            res.immediate    = {24'd0, b[3]};
            res.length       = 4'd4;
          end
        end else begin
          res.status = x86d_pkg::ST_UNSUP;
        end
      end
      x86d_pkg::OP_PUSH_IMM32: begin
        res.kind      = x86d_pkg::KIND_PUSH_IMM32;
        res.length    = 4'd5;
        res.immediate = b[4:1];
      end
      x86d_pkg::OP_PUSH_IMM8: begin
        res.kind      = x86d_pkg::KIND_PUSH_IMM8;
        res.length    = 4'd2;
        res.immediate = {24'd0, b[1]};
      end
      x86d_pkg::OP_CALL: begin
        res.kind   = x86d_pkg::KIND_CALL;
        res.length = 4'd5;
        offset     = b[4:1];
        is_branch  = 1'b1;
      end
      x86d_pkg::OP_JNE, x86d_pkg::OP_JMP: begin
        res.kind   = (op == x86d_pkg::OP_JNE) ? x86d_pkg::KIND_JNE : x86d_pkg::KIND_JMP;
        res.length = 4'd2;
        offset     = x86d_pkg::sext8(b[1]);
        is_branch  = 1'b1;
      end
      [x86d_pkg::OP_MOV_IMM:x86d_pkg::OP_MOV_IMM_LAST]: begin
        res.kind      = x86d_pkg::KIND_MOV_IMM;
        res.length    = 4'd5;
        res.reg_field = op[2:0];
        res.immediate = b[4:1];
      end
      x86d_pkg::OP_GRP5: begin
        if (mreg == x86d_pkg::EXT_PUSH) begin
          res.kind         = x86d_pkg::KIND_PUSH_RM;
          res.reg_field    = mreg;
          res.rm_field     = b[1][2:0];
          res.addr_mode    = rm.mode;
          res.displacement = rm.disp;
          res.length       = 4'd2 + {1'b0, rm.n};
        end else begin
          res.status = x86d_pkg::ST_UNSUP;
        end
      end
      x86d_pkg::OP_MOVL: begin
        if (mreg == x86d_pkg::EXT_MOVL) begin
          res.kind         = x86d_pkg::KIND_MOVL;
          res.reg_field    = mreg;
          res.rm_field     = b[1][2:0];
          res.addr_mode    = rm.mode;
          res.displacement = rm.disp;
          res.length       = 4'd6 + {1'b0, rm.n};
          case (rm.n)
            3'd1:    res.immediate = b[6:3];
            3'd4:    res.immediate = b[9:6];
            default: res.immediate = b[5:2];
          endcase
        end else begin
          res.status = x86d_pkg::ST_UNSUP;
        end
      end
      default: begin
        res.status = x86d_pkg::ST_UNKNOWN;
        res.length = 4'd1;
      end
    endcase
    if (is_branch) begin
      res.branch_target = insn.addr + {28'd0, res.length} + offset;
    end
  end

endmodule
